// ===== sv/tsfc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the temperature
// sensor frame checker. No dependencies.

package tsfc_pkg;

  // input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } tsfc_in_t;

  // result transfer payload
  typedef struct packed {
    logic [7:0] temperature;
    logic       crc_ok;
  } tsfc_out_t;

  localparam int unsigned PosWidth = 4;

  // reflected polynomial taps and the result used on a crc mismatch
  localparam logic [7:0] CrcTaps     = 8'h18;
  localparam logic [7:0] CrcTopBit   = 8'h80;
  localparam logic [7:0] CrcFailCode = 8'd175;

  // one byte through the reflected dallas crc-8, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    crc  = crc_in;
    data = data_in;
    for (int k = 0; k < 8; k++) begin
      if ((crc[0] ^ data[0]) == 1'b1) begin
        crc = ((crc ^ CrcTaps) >> 1) | CrcTopBit;
      end else begin
        crc = crc >> 1;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

// ===== sv/tsfc_in_reg.sv =====
// Input register stage of the temperature sensor frame checker.
// Depends on tsfc_pkg for the input payload type.

module tsfc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsfc_pkg::tsfc_in_t in_data_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output tsfc_pkg::tsfc_in_t item_o
);

  logic              valid_q, valid_d;
  tsfc_pkg::tsfc_in_t data_q;

  // slot is free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture on an input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ===== sv/tsfc_check.sv =====
// Frame state, crc update, check and result register of the temperature
// sensor frame checker. Depends on tsfc_pkg for types, constants and crc8_byte.

module tsfc_check #(
  parameter int unsigned FRAME_LENGTH = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  tsfc_pkg::tsfc_in_t  item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsfc_pkg::tsfc_out_t out_data_o
);

  localparam logic [tsfc_pkg::PosWidth-1:0] LastPos =
    tsfc_pkg::PosWidth'(FRAME_LENGTH - 1);

  logic [tsfc_pkg::PosWidth-1:0] pos_q, pos_d, pos_w;
  logic [7:0]                    crc_q, crc_d, crc_w;
  logic [7:0]                    low_q, low_d, high_q, high_d;
  logic                          out_valid_q, out_valid_d;
  tsfc_pkg::tsfc_out_t           out_q, result_w;
  logic                          last_w;

  // frame start restarts position and crc before this byte
  assign pos_w  = item_i.frame_start ? '0 : pos_q;
  assign crc_w  = item_i.frame_start ? '0 : crc_q;
  assign last_w = (pos_w >= LastPos);

  // a data byte always moves on; the check byte needs a free result slot
  assign item_take_o = item_valid_i && (!last_w || !out_valid_q || out_ready_i);

  // check result
  always_comb begin
    result_w.crc_ok = (crc_w == item_i.data_byte);
    if (result_w.crc_ok) begin
      result_w.temperature = {high_q[3:0], low_q[7:4]};
    end else begin
      result_w.temperature = tsfc_pkg::CrcFailCode;
    end
  end

  // frame state update
  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    low_d  = low_q;
    high_d = high_q;
    if (item_take_o) begin
      if (last_w) begin
        pos_d = '0;
        crc_d = '0;
      end else begin
        if (pos_w == '0) begin
          low_d = item_i.data_byte;
        end
        if (pos_w == tsfc_pkg::PosWidth'(1)) begin
          high_d = item_i.data_byte;
        end
        crc_d = tsfc_pkg::crc8_byte(crc_w, item_i.data_byte);
        pos_d = pos_w + tsfc_pkg::PosWidth'(1);
      end
    end
  end

  // result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o && last_w) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload capture
  always_ff @(posedge clk_i) begin
    if (item_take_o && last_w) begin
      out_q <= result_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // position never passes the check byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= LastPos)
    else $error("frame position beyond check byte");

  // check byte closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && last_w) |=> (pos_q == '0 && crc_q == '0))
    else $error("frame state not cleared after check byte");

  // a new result appears only after a check byte was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(item_take_o && last_w))
    else $error("result without check byte");

  // a failed check always carries the fail code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.crc_ok || out_q.temperature == tsfc_pkg::CrcFailCode))
    else $error("crc failure without fail code");

endmodule

// ===== sv/temp_sensor_frame_checker_core.sv =====
// Temperature sensor frame checker: checks the crc-8 of a scratchpad frame
// and delivers the whole-degree reading. Depends on tsfc_pkg, tsfc_in_reg
// and tsfc_check.
//
// Usage: scratchpad bytes arrive one per transfer on the input channel
// (in_valid_i / in_ready_o / in_data_i), byte 0 first; frame_start marks
// byte 0 and restarts the frame. Bytes 0 to FRAME_LENGTH-2 feed the crc and
// give no result. The byte at position FRAME_LENGTH-1 is the received crc;
// it yields one result transfer (out_valid_o / out_ready_i / out_data_o)
// carrying the temperature, or code 175 with crc_ok low on a mismatch.
// The check byte passes the input register and then the result register,
// which presents the reading. Throughput: one byte per cycle, set by the
// unrolled combinational crc update on the frame state, while no check
// byte waits on a held result.
// Reset clears the frame position, crc, stored readings and both valid
// flags. While the receiver stalls, the held result stays put and data bytes
// keep flowing; only a further check byte waits until the result is taken.

module temp_sensor_frame_checker_core #(
  parameter int unsigned FRAME_LENGTH = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsfc_pkg::tsfc_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsfc_pkg::tsfc_out_t out_data_o
);

  logic               item_valid;
  logic               item_take;
  tsfc_pkg::tsfc_in_t item;

  // input register
  tsfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  // frame check and result register
  tsfc_check #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
